// File: rtl/csvfs_pkg.sv
// Shared types and constants for the CSV field splitter.
`timescale 1ns / 1ps

package csvfs_pkg;

  localparam int MAX_FIELDS_PER_LINE = 32;
  localparam int FIELD_BUFFER_BYTES  = 8192;

  localparam int BYTE_W   = 8;
  localparam int FNUM_W   = 5;
  localparam int FLEN_W   = 13;

  localparam logic [BYTE_W-1:0] QUOTE_DOUBLE = 8'd34;
  localparam logic [BYTE_W-1:0] QUOTE_APOS   = 8'd39;
  localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd44;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              is_field_end;
    logic [BYTE_W-1:0] char_value;
    logic [FNUM_W-1:0] field_number;
    logic [FLEN_W-1:0] field_length;
    logic              last;
  } item_t;

  // up to two items come out of one input byte: a character or field end,
  // then the closing field end of the line
  typedef struct packed {
    logic  a_valid;
    item_t a;
    logic  b_valid;
    item_t b;
  } parse_out_t;

endpackage

// File: rtl/csvfs_parse.sv
// Per-byte tokenizer state and item generation for the CSV field splitter.
`timescale 1ns / 1ps

module csvfs_parse #(
  parameter int MAX_FIELDS_PER_LINE = csvfs_pkg::MAX_FIELDS_PER_LINE,
  parameter int FIELD_BUFFER_BYTES  = csvfs_pkg::FIELD_BUFFER_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [csvfs_pkg::BYTE_W-1:0]   data_byte,
  input  logic                           apostrophe_quotes,
  input  logic                           line_end,
  input  logic [csvfs_pkg::BYTE_W-1:0]   delimiter,
  output csvfs_pkg::parse_out_t          items
);
  import csvfs_pkg::*;

  localparam int FD_W = $clog2(MAX_FIELDS_PER_LINE + 1);
  localparam int CF_W = $clog2(FIELD_BUFFER_BYTES);
  localparam logic [FD_W-1:0] FD_MAX   = FD_W'(MAX_FIELDS_PER_LINE);
  localparam logic [CF_W-1:0] CF_LIMIT = CF_W'(FIELD_BUFFER_BYTES - 1);

  logic            inside_quotes_r, inside_quotes_nxt;
  logic            quote_pending_r, quote_pending_nxt;
  logic [FD_W-1:0] fields_done_r,   fields_done_nxt;
  logic [CF_W-1:0] chars_r,         chars_nxt;

  logic [BYTE_W-1:0] quote_byte;
  logic              consumed;
  logic              is_quote;
  logic              keep;
  logic [BYTE_W-1:0] keep_val;

  assign quote_byte = apostrophe_quotes ? QUOTE_APOS : QUOTE_DOUBLE;
  assign is_quote   = (data_byte == quote_byte);

  always_comb begin
    inside_quotes_nxt = inside_quotes_r;
    quote_pending_nxt = quote_pending_r;
    fields_done_nxt   = fields_done_r;
    chars_nxt         = chars_r;
    consumed          = 1'b0;
    keep              = 1'b0;
    keep_val          = data_byte;
    items             = '0;

    if (fields_done_r < FD_MAX) begin
      if (quote_pending_r) begin
        quote_pending_nxt = 1'b0;
        if (is_quote) begin
          // doubled quote inside quotes: one literal quote
          keep     = 1'b1;
          keep_val = quote_byte;
          consumed = 1'b1;
        end else begin
          inside_quotes_nxt = 1'b0;
        end
      end
      if (!consumed) begin
        if (is_quote) begin
          if (inside_quotes_nxt) begin
            quote_pending_nxt = 1'b1;
          end else begin
            inside_quotes_nxt = 1'b1;
          end
        end else if (data_byte == delimiter && !inside_quotes_nxt) begin
          items.a_valid              = 1'b1;
          items.a.is_field_end       = 1'b1;
          items.a.field_number       = FNUM_W'(fields_done_r);
          items.a.field_length       = FLEN_W'(chars_r);
          fields_done_nxt            = fields_done_r + FD_W'(1);
          items.a.last               = (fields_done_nxt >= FD_MAX);
          chars_nxt                  = '0;
        end else begin
          keep = 1'b1;
        end
      end
      if (keep && chars_r < CF_LIMIT) begin
        items.a_valid        = 1'b1;
        items.a.char_value   = keep_val;
        items.a.field_number = FNUM_W'(fields_done_r);
        chars_nxt            = chars_r + CF_W'(1);
      end
    end

    if (line_end) begin
      if (fields_done_nxt < FD_MAX) begin
        items.b_valid        = 1'b1;
        items.b.is_field_end = 1'b1;
        items.b.field_number = FNUM_W'(fields_done_nxt);
        items.b.field_length = FLEN_W'(chars_nxt);
        items.b.last         = 1'b1;
      end
      inside_quotes_nxt = 1'b0;
      quote_pending_nxt = 1'b0;
      fields_done_nxt   = '0;
      chars_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r <= 1'b0;
      quote_pending_r <= 1'b0;
      fields_done_r   <= '0;
      chars_r         <= '0;
    end else if (accept) begin
      inside_quotes_r <= inside_quotes_nxt;
      quote_pending_r <= quote_pending_nxt;
      fields_done_r   <= fields_done_nxt;
      chars_r         <= chars_nxt;
    end
  end

endmodule

// File: rtl/csv_field_splitter_core.sv
// Top level of the CSV field splitter: config register, tokenizer, result queue.
// Results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle; a line-end byte may give two results, drained one per
// cycle while out_stall is low, from a 4-entry queue; input stalls under two slots free.
// Reset: synchronous active-low rst_n clears parse state and queue, delimiter to comma.
`timescale 1ns / 1ps

module csv_field_splitter_core #(
  parameter int MAX_FIELDS_PER_LINE = csvfs_pkg::MAX_FIELDS_PER_LINE,
  parameter int FIELD_BUFFER_BYTES  = csvfs_pkg::FIELD_BUFFER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csvfs_pkg::BYTE_W-1:0]  cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csvfs_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          in_apostrophe_quotes,
  input  logic                          in_line_end,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_field_end,
  output logic [csvfs_pkg::BYTE_W-1:0]  out_char_value,
  output logic [csvfs_pkg::FNUM_W-1:0]  out_field_number,
  output logic [csvfs_pkg::FLEN_W-1:0]  out_field_length,
  output logic                          out_last
);
  import csvfs_pkg::*;

  logic [BYTE_W-1:0] delimiter_r;
  logic              in_accept;
  logic              out_pop;
  parse_out_t        items;

  item_t             queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic [1:0]        push_n;
  logic [QPTR_W-1:0] b_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= DELIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delimiter_r <= cfg_data;
    end
  end

  // keep room for the two results a single byte can produce
  assign in_stall  = (count_r > QCNT_W'(QUEUE_DEPTH - 2));
  assign in_accept = in_valid && !in_stall;

  csvfs_parse #(
    .MAX_FIELDS_PER_LINE (MAX_FIELDS_PER_LINE),
    .FIELD_BUFFER_BYTES  (FIELD_BUFFER_BYTES)
  ) u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .data_byte         (in_data_byte),
    .apostrophe_quotes (in_apostrophe_quotes),
    .line_end          (in_line_end),
    .delimiter         (delimiter_r),
    .items             (items)
  );

  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;

  assign push_n     = in_accept ? ({1'b0, items.a_valid} + {1'b0, items.b_valid}) : 2'd0;
  assign b_slot     = wr_ptr_r + QPTR_W'(items.a_valid);
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(out_pop);
  assign count_nxt  = count_r + QCNT_W'(push_n) - QCNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (items.a_valid) begin
        queue_r[wr_ptr_r] <= items.a;
      end
      if (items.b_valid) begin
        queue_r[b_slot] <= items.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_is_field_end = queue_r[rd_ptr_r].is_field_end;
  assign out_char_value   = queue_r[rd_ptr_r].char_value;
  assign out_field_number = queue_r[rd_ptr_r].field_number;
  assign out_field_length = queue_r[rd_ptr_r].field_length;
  assign out_last         = queue_r[rd_ptr_r].last;

endmodule
